// ----- hdl/spq_pkg.sv -----
package spq_pkg;

  localparam int unsigned CAPACITY    = 64;
  localparam int unsigned KEY_BITS    = 16;
  localparam int unsigned HANDLE_BITS = 16;

  localparam int unsigned CMD_BITS  = 2;
  localparam int unsigned RANK_BITS = 6;
  localparam int unsigned STAT_BITS = 2;
  localparam int unsigned OCC_BITS  = 7;

  localparam int unsigned CNT_BITS = $clog2(CAPACITY + 1);
  localparam int unsigned CMP_BITS = (RANK_BITS > CNT_BITS) ? RANK_BITS : CNT_BITS;

  typedef enum logic [CMD_BITS-1:0] {
    CMD_INSERT = 2'd0,
    CMD_POP    = 2'd1,
    CMD_READ   = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_e;

  typedef enum logic [STAT_BITS-1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2,
    STAT_RANGE = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_POP,
    CELL_LOAD,
    CELL_SHIFT
  } cell_op_e;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_e;

  typedef struct packed {
    logic [HANDLE_BITS-1:0] handle;
    logic [KEY_BITS-1:0]    key;
  } entry_t;

  typedef struct packed {
    cell_op_e op;
    entry_t   new_entry;
  } cell_ctrl_t;

endpackage

// ----- hdl/spq_req_if.sv -----
interface spq_req_if import spq_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic [CMD_BITS-1:0]         cmd;
  logic [HANDLE_BITS-1:0]      handle;
  logic signed [KEY_BITS-1:0]  key;
  logic [RANK_BITS-1:0]        rank;

  modport source (output valid, cmd, handle, key, rank, input ready);
  modport sink   (input valid, cmd, handle, key, rank, output ready);
endinterface

// ----- hdl/spq_rsp_if.sv -----
interface spq_rsp_if import spq_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic [HANDLE_BITS-1:0]      out_handle;
  logic signed [KEY_BITS-1:0]  out_key;
  logic                        hit;
  logic [STAT_BITS-1:0]        status;
  logic [OCC_BITS-1:0]         occupancy;

  modport source (output valid, out_handle, out_key, hit, status, occupancy, input ready);
  modport sink   (input valid, out_handle, out_key, hit, status, occupancy, output ready);
endinterface

// ----- hdl/sorted_priority_queue.sv -----
// Sorted priority queue of up to 64 entries, each a 16-bit handle and a signed
// 16-bit key, held in a row of cells in descending key order; an insert lands
// behind every entry with an equal or larger key, so equal keys leave first in,
// first out. One request is worked at a time and each gives exactly one
// response carrying the occupancy after it. Insert, pop, clear and a read
// beyond the count are answered from the idle state. A read at rank r copies
// the row into a second chain of read registers that moves one cell toward the
// head per cycle until rank r is at the head. A new request is taken no earlier
// than the cycle in which the last response is taken, and never while scanning.
module sorted_priority_queue import spq_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  spq_req_if.sink   req_i,
  spq_rsp_if.source rsp_o
);

  state_e                  state_q, state_d;
  logic [CNT_BITS-1:0]     fill_q, fill_d;
  logic [RANK_BITS-1:0]    scan_cnt_q, scan_cnt_d;

  logic                    out_valid_q, out_valid_d;
  entry_t                  out_entry_q, out_entry_d;
  logic                    out_hit_q, out_hit_d;
  status_e                 out_status_q, out_status_d;
  logic [OCC_BITS-1:0]     out_occ_q, out_occ_d;

  cell_ctrl_t              cell_ctrl;
  entry_t                  cell_entry [CAPACITY];
  entry_t                  cell_rd    [CAPACITY];
  logic                    cell_ge    [CAPACITY];

  logic                    out_free;
  logic                    accept;
  logic                    full;
  logic                    empty;
  logic                    rank_ok;
  cmd_e                    cmd;

  assign out_free = !out_valid_q || rsp_o.ready;
  assign req_i.ready = (state_q == ST_IDLE) && out_free;
  assign accept = req_i.valid && req_i.ready;
  assign cmd = cmd_e'(req_i.cmd);
  assign full = (fill_q == CNT_BITS'(CAPACITY));
  assign empty = (fill_q == '0);
  assign rank_ok = CMP_BITS'(req_i.rank) < CMP_BITS'(fill_q);

  always_comb begin
    state_d      = state_q;
    fill_d       = fill_q;
    scan_cnt_d   = scan_cnt_q;
    out_entry_d  = out_entry_q;
    out_hit_d    = out_hit_q;
    out_status_d = out_status_q;
    out_occ_d    = out_occ_q;
    out_valid_d  = out_valid_q && !rsp_o.ready;
    cell_ctrl.op = CELL_HOLD;
    cell_ctrl.new_entry.handle = req_i.handle;
    cell_ctrl.new_entry.key    = req_i.key;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          out_valid_d  = 1'b1;
          out_entry_d  = '0;
          out_hit_d    = 1'b0;
          out_status_d = STAT_OK;
          case (cmd)
            CMD_INSERT: begin
              if (full) begin
                out_status_d = STAT_FULL;
              end else begin
                cell_ctrl.op = CELL_INSERT;
                fill_d = fill_q + 1'b1;
              end
            end
            CMD_POP: begin
              if (empty) begin
                out_status_d = STAT_EMPTY;
              end else begin
                cell_ctrl.op = CELL_POP;
                out_entry_d  = cell_entry[0];
                out_hit_d    = 1'b1;
                fill_d = fill_q - 1'b1;
              end
            end
            CMD_READ: begin
              if (rank_ok) begin
                cell_ctrl.op = CELL_LOAD;
                scan_cnt_d   = req_i.rank;
                out_valid_d  = 1'b0;
                state_d      = ST_SCAN;
              end else begin
                out_status_d = STAT_RANGE;
              end
            end
            CMD_CLEAR: begin
              fill_d = '0;
            end
            default: begin
              fill_d = fill_q;
            end
          endcase
          out_occ_d = OCC_BITS'(fill_d);
        end
      end
      ST_SCAN: begin
        if (scan_cnt_q != '0) begin
          cell_ctrl.op = CELL_SHIFT;
          scan_cnt_d   = scan_cnt_q - 1'b1;
        end else if (out_free) begin
          out_valid_d  = 1'b1;
          out_entry_d  = cell_rd[0];
          out_hit_d    = 1'b1;
          out_status_d = STAT_OK;
          out_occ_d    = OCC_BITS'(fill_q);
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic   left_ge;
    entry_t left_entry;
    entry_t right_entry;
    entry_t right_rd;

    if (i == 0) begin : g_head
      assign left_ge    = 1'b1;
      assign left_entry = cell_ctrl.new_entry;
    end else begin : g_body
      assign left_ge    = cell_ge[i-1];
      assign left_entry = cell_entry[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_entry = cell_entry[i];
      assign right_rd    = cell_rd[i];
    end else begin : g_mid
      assign right_entry = cell_entry[i+1];
      assign right_rd    = cell_rd[i+1];
    end

    spq_cell u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (cell_ctrl),
      .occupied_i   (CNT_BITS'(i) < fill_q),
      .left_ge_i    (left_ge),
      .left_entry_i (left_entry),
      .right_entry_i(right_entry),
      .right_rd_i   (right_rd),
      .entry_o      (cell_entry[i]),
      .ge_o         (cell_ge[i]),
      .rd_o         (cell_rd[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fill_q      <= '0;
      scan_cnt_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      scan_cnt_q  <= scan_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_entry_q  <= out_entry_d;
    out_hit_q    <= out_hit_d;
    out_status_q <= out_status_d;
    out_occ_q    <= out_occ_d;
  end

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.out_handle = out_entry_q.handle;
  assign rsp_o.out_key    = out_entry_q.key;
  assign rsp_o.hit        = out_hit_q;
  assign rsp_o.status     = out_status_q;
  assign rsp_o.occupancy  = out_occ_q;

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CNT_BITS'(CAPACITY))
    else $error("fill count above capacity");

  a_scan_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) && (scan_cnt_q != '0) |=>
      (state_q == ST_SCAN) && (scan_cnt_q == $past(scan_cnt_q) - 1'b1))
    else $error("read scan did not step toward the head");

  a_pop_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (cmd == CMD_POP) && !empty |=> fill_q == $past(fill_q) - 1'b1)
    else $error("pop did not drop the fill count");

  a_hit_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_hit_q |-> out_status_q == STAT_OK)
    else $error("hit reported with error status");

endmodule

// ----- hdl/spq_cell.sv -----
module spq_cell import spq_pkg::*; (
  input  logic       clk_i,
  input  cell_ctrl_t ctrl_i,
  input  logic       occupied_i,
  input  logic       left_ge_i,
  input  entry_t     left_entry_i,
  input  entry_t     right_entry_i,
  input  entry_t     right_rd_i,
  output entry_t     entry_o,
  output logic       ge_o,
  output entry_t     rd_o
);

  entry_t entry_q, entry_d;
  entry_t rd_q, rd_d;

  // entry stays in place when its key is at least the new one
  assign ge_o = occupied_i &&
                ($signed(entry_q.key) >= $signed(ctrl_i.new_entry.key));

  always_comb begin
    entry_d = entry_q;
    rd_d    = rd_q;
    case (ctrl_i.op)
      CELL_INSERT: begin
        if (ge_o) begin
          entry_d = entry_q;
        end else if (left_ge_i) begin
          entry_d = ctrl_i.new_entry;
        end else begin
          entry_d = left_entry_i;
        end
      end
      CELL_POP: begin
        entry_d = right_entry_i;
      end
      CELL_LOAD: begin
        rd_d = entry_q;
      end
      CELL_SHIFT: begin
        rd_d = right_rd_i;
      end
      default: begin
        entry_d = entry_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
    rd_q    <= rd_d;
  end

  assign entry_o = entry_q;
  assign rd_o    = rd_q;

endmodule

// ----- dv/spq_checker.sv -----
module spq_checker import spq_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  spq_req_if          req_i,
  spq_rsp_if          rsp_i,
  output int unsigned mismatches_o,
  output int unsigned outstanding_o,
  output int unsigned compared_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [HANDLE_BITS-1:0]     handle;
    logic signed [KEY_BITS-1:0] key;
    logic                       hit;
    status_e                    status;
    logic [OCC_BITS-1:0]        occupancy;
  } outcome_t;

  logic [HANDLE_BITS-1:0]     held_handle [CAPACITY];
  logic signed [KEY_BITS-1:0] held_key    [CAPACITY];
  int unsigned                held_count;
  outcome_t                   due_outcomes [$];

  // sorted-array queue: descending keys, equal keys in arrival order
  function automatic outcome_t apply_request(cmd_e cmd, logic [HANDLE_BITS-1:0] handle,
                                             logic signed [KEY_BITS-1:0] key,
                                             logic [RANK_BITS-1:0] rank);
    outcome_t    res;
    int unsigned pos;
    res = '{handle: '0, key: '0, hit: 1'b0, status: STAT_OK, occupancy: '0};
    case (cmd)
      CMD_INSERT: begin
        if (held_count == CAPACITY) begin
          res.status = STAT_FULL;
        end else begin
          pos = held_count;
          while (pos > 0 && held_key[pos-1] < key) begin
            held_key[pos]    = held_key[pos-1];
            held_handle[pos] = held_handle[pos-1];
            pos--;
          end
          held_key[pos]    = key;
          held_handle[pos] = handle;
          held_count++;
        end
      end
      CMD_POP: begin
        if (held_count == 0) begin
          res.status = STAT_EMPTY;
        end else begin
          res.handle = held_handle[0];
          res.key    = held_key[0];
          res.hit    = 1'b1;
          for (pos = 1; pos < held_count; pos++) begin
            held_key[pos-1]    = held_key[pos];
            held_handle[pos-1] = held_handle[pos];
          end
          held_count--;
        end
      end
      CMD_READ: begin
        if (rank >= held_count) begin
          res.status = STAT_RANGE;
        end else begin
          res.handle = held_handle[rank];
          res.key    = held_key[rank];
          res.hit    = 1'b1;
        end
      end
      CMD_CLEAR: begin
        held_count = 0;
      end
      default: ;
    endcase
    res.occupancy = OCC_BITS'(held_count);
    return res;
  endfunction

  function void check_field(string name, logic signed [31:0] want, logic signed [31:0] seen);
    if (seen !== want) begin
      $error("%s: expected %0d, got %0d", name, want, seen);
      mismatches_o++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    outcome_t want;
    if (!rst_ni) begin
      due_outcomes.delete();
      held_count    = 0;
      mismatches_o  = 0;
      outstanding_o = 0;
      compared_o    = 0;
    end else begin
      // predict first so a same-edge response still finds its request
      if (req_i.valid && req_i.ready) begin
        due_outcomes.push_back(apply_request(cmd_e'(req_i.cmd), req_i.handle, req_i.key,
                                             req_i.rank));
      end
      if (rsp_i.valid && rsp_i.ready) begin
        if (due_outcomes.size() == 0) begin
          $error("response with no request waiting: handle %0d key %0d status %0d",
                 rsp_i.out_handle, rsp_i.out_key, rsp_i.status);
          mismatches_o++;
        end else begin
          want = due_outcomes.pop_front();
          check_field("out_handle", want.handle, rsp_i.out_handle);
          check_field("out_key", want.key, rsp_i.out_key);
          check_field("hit", want.hit, rsp_i.hit);
          check_field("status", want.status, rsp_i.status);
          check_field("occupancy", want.occupancy, rsp_i.occupancy);
          compared_o++;
        end
      end
      outstanding_o = due_outcomes.size();
    end
  end

endmodule

// ----- dv/testbench.sv -----
module testbench import spq_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned STIM_ITEMS = 1325;

  typedef enum {PH_FILL, PH_EMPTY, PH_MIXED} phase_e;

  logic clk_i;
  logic rst_ni;

  spq_req_if req_if ();
  spq_rsp_if rsp_if ();

  int unsigned mismatches;
  int unsigned outstanding;
  int unsigned compared;

  int unsigned sent_by_cmd [1 << CMD_BITS];
  int unsigned sent_total;
  int unsigned fill_est;
  int unsigned overflow_tries;
  bit          calm;

  sorted_priority_queue DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  spq_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_i         (req_if),
    .rsp_i         (rsp_if),
    .mismatches_o  (mismatches),
    .outstanding_o (outstanding),
    .compared_o    (compared)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #10_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic int unsigned draw_gap();
    if (calm) begin
      return 0;
    end
    return $urandom_range(0, 8);
  endfunction

  function automatic logic signed [KEY_BITS-1:0] pick_key();
    logic signed [KEY_BITS-1:0] k;
    case ($urandom_range(0, 9))
      0: k = 16'h7FFF;
      1: k = 16'h8000;
      2, 3, 4: begin
        k = KEY_BITS'($urandom_range(0, 8));
        k = k - 16'sd4;
      end
      default: k = KEY_BITS'($urandom);
    endcase
    return k;
  endfunction

  function automatic logic [HANDLE_BITS-1:0] pick_handle();
    case ($urandom_range(0, 15))
      0: return '0;
      1: return '1;
      default: return HANDLE_BITS'($urandom);
    endcase
  endfunction

  function automatic logic [RANK_BITS-1:0] pick_rank();
    if (fill_est > 0 && $urandom_range(0, 4) != 0) begin
      return RANK_BITS'($urandom_range(0, fill_est - 1));
    end
    return RANK_BITS'($urandom_range(0, (1 << RANK_BITS) - 1));
  endfunction

  task automatic put_request(input cmd_e cmd, input logic [HANDLE_BITS-1:0] handle,
                             input logic signed [KEY_BITS-1:0] key,
                             input logic [RANK_BITS-1:0] rank);
    int unsigned gap;
    gap = draw_gap();
    repeat (gap) begin
      @(negedge clk_i);
      req_if.valid <= 1'b0;
    end
    @(negedge clk_i);
    req_if.valid  <= 1'b1;
    req_if.cmd    <= cmd;
    req_if.handle <= handle;
    req_if.key    <= key;
    req_if.rank   <= rank;
    do @(posedge clk_i); while (!req_if.ready);
    case (cmd)
      CMD_INSERT: begin
        if (fill_est < CAPACITY) fill_est++;
        else overflow_tries++;
      end
      CMD_POP: if (fill_est > 0) fill_est--;
      CMD_CLEAR: fill_est = 0;
      default: ;
    endcase
    sent_by_cmd[cmd]++;
    sent_total++;
  endtask

  // hold off new requests until every response is back
  task automatic drain_responses();
    @(negedge clk_i);
    req_if.valid <= 1'b0;
    while (outstanding != 0) @(negedge clk_i);
  endtask

  initial begin : responder
    int unsigned stall;
    rsp_if.ready = 1'b0;
    forever begin
      stall = draw_gap();
      repeat (stall) begin
        @(negedge clk_i);
        rsp_if.ready <= 1'b0;
      end
      @(negedge clk_i);
      rsp_if.ready <= 1'b1;
      do @(posedge clk_i); while (!rsp_if.valid);
    end
  end

  initial begin : stimulus
    phase_e      phase;
    bit          first;
    int unsigned r;
    int unsigned n;
    rst_ni         = 1'b0;
    req_if.valid   = 1'b0;
    req_if.cmd     = CMD_INSERT;
    req_if.handle  = '0;
    req_if.key     = '0;
    req_if.rank    = '0;
    calm           = 1'b0;
    sent_total     = 0;
    fill_est       = 0;
    overflow_tries = 0;
    foreach (sent_by_cmd[i]) sent_by_cmd[i] = 0;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;

    // empty queue corner cases
    put_request(CMD_POP, '0, '0, '0);
    put_request(CMD_READ, '0, '0, '0);
    put_request(CMD_READ, '0, '0, '1);
    put_request(CMD_CLEAR, '0, '0, '0);
    // key extremes and equal keys
    put_request(CMD_INSERT, 16'hFFFF, 16'h7FFF, '0);
    put_request(CMD_INSERT, 16'h0000, 16'h8000, '0);
    put_request(CMD_INSERT, 16'h1234, 16'h0000, '0);
    put_request(CMD_INSERT, 16'h5678, 16'h0000, '0);
    put_request(CMD_INSERT, 16'hABCD, 16'hFFFF, '0);
    put_request(CMD_INSERT, 16'h0001, 16'h7FFF, '0);
    for (int unsigned k = 0; k < 7; k++) put_request(CMD_READ, '0, '0, RANK_BITS'(k));
    put_request(CMD_READ, '0, '0, '1);
    repeat (3) put_request(CMD_POP, '0, '0, '0);
    put_request(CMD_CLEAR, '0, '0, '0);
    put_request(CMD_POP, '0, '0, '0);
    put_request(CMD_READ, '0, '0, '0);
    put_request(CMD_INSERT, 16'h5A5A, 16'h0001, '0);
    put_request(CMD_POP, '0, '0, '0);
    drain_responses();

    first = 1'b1;
    while (sent_total < STIM_ITEMS) begin
      if (first) begin
        phase = PH_FILL;
      end else begin
        r = $urandom_range(0, 5);
        phase = (r == 0) ? PH_FILL : (r == 1) ? PH_EMPTY : PH_MIXED;
      end
      calm = ($urandom_range(0, 3) == 0);
      case (phase)
        PH_FILL: begin
          while (fill_est < CAPACITY) put_request(CMD_INSERT, pick_handle(), pick_key(), '0);
          repeat ($urandom_range(1, 3)) put_request(CMD_INSERT, pick_handle(), pick_key(), '0);
          put_request(CMD_READ, '0, '0, RANK_BITS'(CAPACITY - 1));
        end
        PH_EMPTY: begin
          while (fill_est > 0) begin
            if ($urandom_range(0, 6) == 0) put_request(CMD_READ, pick_handle(), pick_key(),
                                                       pick_rank());
            else put_request(CMD_POP, pick_handle(), pick_key(), pick_rank());
          end
          repeat ($urandom_range(1, 3)) put_request(CMD_POP, pick_handle(), pick_key(), '0);
        end
        default: begin
          n = $urandom_range(20, 80);
          repeat (n) begin
            r = $urandom_range(0, 99);
            if (r < 40) put_request(CMD_INSERT, pick_handle(), pick_key(), pick_rank());
            else if (r < 70) put_request(CMD_POP, pick_handle(), pick_key(), pick_rank());
            else if (r < 97) put_request(CMD_READ, pick_handle(), pick_key(), pick_rank());
            else put_request(CMD_CLEAR, pick_handle(), pick_key(), pick_rank());
          end
        end
      endcase
      if (first || $urandom_range(0, 2) == 0) drain_responses();
      first = 1'b0;
    end

    calm = 1'b0;
    drain_responses();
    repeat (100) @(negedge clk_i);
    $display("sent %0d requests: %0d insert, %0d pop, %0d read, %0d clear", sent_total,
             sent_by_cmd[CMD_INSERT], sent_by_cmd[CMD_POP], sent_by_cmd[CMD_READ],
             sent_by_cmd[CMD_CLEAR]);
    $display("%0d responses compared, %0d inserts into a full queue", compared,
             overflow_tries);
    if (mismatches == 0 && outstanding == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
